>>> rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants for the bucket insertion sorter: word field
// widths, default sizes, controller states and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

  // word field widths
  localparam int unsigned VAL_W  = 7;
  localparam int unsigned DROP_W = 7;

  // drop counter saturation value
  localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

  // default sizes
  localparam int unsigned NUM_BUCKETS_DEF  = 8;
  localparam int unsigned BUCKET_DEPTH_DEF = 8;
  localparam int unsigned BUCKET_SPAN_DEF  = 10;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;       // latch input word and its bucket index
    logic rd_store;     // read the row of the incoming word's bucket
    logic write_row;    // write back the row with the new word inserted
    logic drop;         // count a dropped word
    logic walk_sel;     // fill and row lookups follow the output walk
    logic emit_rd;      // read the row under the output walk
    logic next_bucket;  // move the output walk to the next bucket
    logic emit_load;    // load the output register from the current row
    logic empty_load;   // load the output register with the empty result
    logic clear_set;    // clear buckets and counters after the run
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop_hit;     // incoming word is out of range or its bucket is full
    logic last_item;    // incoming word closes the set
    logic set_empty;    // nothing stored
    logic bucket_done;  // every word of the walked bucket has gone out
    logic final_item;   // one stored word left to send
    logic out_free;     // output register can take a word this cycle
  } status_t;

endpackage

>>> rtl/bis_row_mem.sv
// ----------------------------------------------------------------------------
// bis_row_mem
// Bucket store: one row per bucket, each row holding the bucket's words side
// by side. One write port and one registered read port.
// ----------------------------------------------------------------------------
module bis_row_mem #(
  parameter int unsigned NUM_ROWS = 8,
  parameter int unsigned ROW_W    = 56,
  parameter int unsigned ADDR_W   = 3
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [ROW_W-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [ROW_W-1:0]  rd_data_o
);

  logic [ROW_W-1:0] mem [NUM_ROWS];
  logic [ROW_W-1:0] rd_data_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/bis_dpath.sv
// ----------------------------------------------------------------------------
// bis_dpath
// Datapath: bucket index by reciprocal multiply, fill counters, row store,
// parallel insertion into a row, drop and stored-word counters, and the
// output register.
// ----------------------------------------------------------------------------
module bis_dpath #(
  parameter int unsigned NUM_BUCKETS  = 8,
  parameter int unsigned BUCKET_DEPTH = 8,
  parameter int unsigned BUCKET_SPAN  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bis_pkg::cmd_t                 cmd_i,
  output bis_pkg::status_t              status_o,
  input  logic [bis_pkg::VAL_W-1:0]     value_i,
  input  logic                          last_in_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [bis_pkg::VAL_W-1:0]     sorted_value_o,
  output logic                          last_out_o,
  output logic                          empty_res_o,
  output logic [bis_pkg::DROP_W-1:0]    dropped_count_o
);

  import bis_pkg::*;

  localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned IDX_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned TOT_W  = $clog2(NUM_BUCKETS * BUCKET_DEPTH + 1);
  localparam int unsigned ROW_W  = BUCKET_DEPTH * VAL_W;

  // exact division of a VAL_W-bit value by the span: multiply and shift
  localparam int unsigned DIV_SH  = VAL_W + $clog2(BUCKET_SPAN);
  localparam int unsigned RECIP   = ((1 << DIV_SH) + BUCKET_SPAN - 1) / BUCKET_SPAN;
  localparam int unsigned RECIP_W = DIV_SH + 1;
  localparam int unsigned PROD_W  = VAL_W + RECIP_W;

  localparam logic [VAL_W-1:0]  NB_LIM   = VAL_W'(NUM_BUCKETS);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BUCKET_DEPTH);

  typedef logic [BUCKET_DEPTH-1:0][VAL_W-1:0] row_t;

  // input word and bucket lookup
  logic [VAL_W-1:0]  value_q;
  logic              last_q;
  logic [BKT_W-1:0]  bkt_q;
  logic              range_ok_q;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  quot;

  // counters and walk
  logic [FILL_W-1:0] fill_q [NUM_BUCKETS];
  logic [FILL_W-1:0] fill_rd;
  logic [BKT_W-1:0]  walk_q;
  logic [FILL_W-1:0] idx_q;
  logic [TOT_W-1:0]  total_q;
  logic [DROP_W-1:0] drop_q;
  logic [BKT_W-1:0]  look_addr;

  // row path
  logic [ROW_W-1:0]        rd_data;
  row_t                    row_rd;
  row_t                    row_new;
  logic [BUCKET_DEPTH-1:0] keep;

  // output register
  logic              out_valid_q;
  logic [VAL_W-1:0]  sorted_q;
  logic              last_out_q;
  logic              empty_q;
  logic [DROP_W-1:0] drop_out_q;
  logic              out_free;

  // bucket index of the arriving word
  assign prod = PROD_W'(value_i) * PROD_W'(RECIP);
  assign quot = prod[DIV_SH +: VAL_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q    <= value_i;
      last_q     <= last_in_i;
      bkt_q      <= quot[BKT_W-1:0];
      range_ok_q <= (quot < NB_LIM);
    end
  end

  // shared lookup address for fill counters and row reads
  assign look_addr = cmd_i.walk_sel ? walk_q : bkt_q;
  assign fill_rd   = fill_q[look_addr];

  // fill counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cmd_i.clear_set) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cmd_i.write_row) begin
      fill_q[bkt_q] <= fill_rd + FILL_W'(1);
    end
  end

  // stored-word count, drop count, output walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      drop_q  <= '0;
      walk_q  <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.clear_set) begin
        total_q <= '0;
      end else if (cmd_i.write_row) begin
        total_q <= total_q + TOT_W'(1);
      end else if (cmd_i.emit_load) begin
        total_q <= total_q - TOT_W'(1);
      end

      if (cmd_i.clear_set) begin
        drop_q <= '0;
      end else if (cmd_i.drop && drop_q != DROP_MAX) begin
        drop_q <= drop_q + DROP_W'(1);
      end

      if (cmd_i.clear_set) begin
        walk_q <= '0;
        idx_q  <= '0;
      end else if (cmd_i.next_bucket) begin
        walk_q <= walk_q + BKT_W'(1);
        idx_q  <= '0;
      end else if (cmd_i.emit_load) begin
        idx_q <= idx_q + FILL_W'(1);
      end
    end
  end

  // row store
  bis_row_mem #(
    .NUM_ROWS (NUM_BUCKETS),
    .ROW_W    (ROW_W),
    .ADDR_W   (BKT_W)
  ) u_row_mem (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.write_row),
    .wr_addr_i (bkt_q),
    .wr_data_i (ROW_W'(row_new)),
    .rd_en_i   (cmd_i.rd_store || cmd_i.emit_rd),
    .rd_addr_i (look_addr),
    .rd_data_o (rd_data)
  );

  assign row_rd = row_t'(rd_data);

  // insertion: entries not above the new word stay, the rest move up one
  always_comb begin
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      keep[i] = (FILL_W'(i) < fill_rd) && (row_rd[i] <= value_q);
    end
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      if (keep[i]) begin
        row_new[i] = row_rd[i];
      end else if (i == 0) begin
        row_new[i] = value_q;
      end else if (keep[(i > 0) ? i - 1 : 0]) begin
        row_new[i] = value_q;
      end else begin
        row_new[i] = row_rd[(i > 0) ? i - 1 : 0];
      end
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.empty_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      sorted_q   <= row_rd[idx_q[IDX_W-1:0]];
      last_out_q <= status_o.final_item;
      empty_q    <= 1'b0;
      drop_out_q <= drop_q;
    end else if (cmd_i.empty_load) begin
      sorted_q   <= '0;
      last_out_q <= 1'b1;
      empty_q    <= 1'b1;
      drop_out_q <= drop_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sorted_value_o  = sorted_q;
  assign last_out_o      = last_out_q;
  assign empty_res_o     = empty_q;
  assign dropped_count_o = drop_out_q;

  // status back to the controller
  assign status_o.drop_hit    = !range_ok_q || (fill_rd == FILL_MAX);
  assign status_o.last_item   = last_q;
  assign status_o.set_empty   = (total_q == '0);
  assign status_o.bucket_done = (idx_q == fill_rd);
  assign status_o.final_item  = (total_q == TOT_W'(1));
  assign status_o.out_free    = out_free;

`ifndef SYNTHESIS
  // a word is only sent from below its bucket's fill level
  a_emit_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> (idx_q < fill_rd))
    else $error("output word taken beyond bucket fill level");

  // insertion never goes into a full bucket
  a_insert_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_row |-> (fill_rd < FILL_MAX))
    else $error("insertion into a full bucket");

  // the output register is never overwritten while a word waits
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_load || cmd_i.empty_load) |-> out_free)
    else $error("output word overwritten");

  // a finished run leaves nothing behind
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_set |=> (total_q == '0) && (drop_q == '0) && (walk_q == '0))
    else $error("counters not cleared after the run");
`endif

endmodule

>>> rtl/bis_ctrl.sv
// ----------------------------------------------------------------------------
// bis_ctrl
// Controller: steps each input word through bucket lookup and row insertion,
// and after the closing word walks the buckets to send the sorted run.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bis_pkg::status_t status_i,
  output bis_pkg::cmd_t    cmd_o
);

  import bis_pkg::*;

  state_e state_q;
  state_e state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (!status_i.drop_hit) begin
          state_d = ST_WRITE;
        end else if (status_i.last_item) begin
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WRITE: begin
        state_d = status_i.last_item ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        if (!status_i.set_empty) begin
          state_d = ST_EMIT_OUT;
        end else if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_OUT: begin
        if (status_i.bucket_done) begin
          state_d = ST_EMIT_RD;
        end else if (status_i.out_free && status_i.final_item) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_READ: begin
        cmd_o.drop     = status_i.drop_hit;
        cmd_o.rd_store = !status_i.drop_hit;
      end
      ST_WRITE: begin
        cmd_o.write_row = 1'b1;
      end
      ST_EMIT_RD: begin
        cmd_o.walk_sel = 1'b1;
        if (!status_i.set_empty) begin
          cmd_o.emit_rd = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.empty_load = 1'b1;
          cmd_o.clear_set  = 1'b1;
        end
      end
      ST_EMIT_OUT: begin
        cmd_o.walk_sel = 1'b1;
        if (status_i.bucket_done) begin
          cmd_o.next_bucket = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.clear_set = status_i.final_item;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/bucket_insertion_sorter.sv
// ----------------------------------------------------------------------------
// bucket_insertion_sorter
// Bucket sort with insertion sort inside each bucket, one word in at a time,
// the sorted run out as a burst after the word flagged last.
// ----------------------------------------------------------------------------
// Each input word is placed in bucket value / BUCKET_SPAN and kept in
// ascending order there; a word whose bucket is out of range or full is
// dropped and counted (saturating at 127). A stored word passes through
// accept, bucket lookup and row read, and row write-back with the insertion
// done across the whole row at once; a dropped word stops after the lookup.
// After the closing word the block sends every stored word, bucket 0 first,
// at one word per cycle while the output is not stalled, with a registered
// row read from the bucket store and an end-of-bucket check for each bucket
// walked; an empty set gives one result flagged empty.
// New words are taken again as soon as the last result sits in the output
// register. Buckets and the drop count clear at the end of every run.
// ----------------------------------------------------------------------------
module bucket_insertion_sorter #(
  parameter int unsigned NUM_BUCKETS  = bis_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_DEPTH = bis_pkg::BUCKET_DEPTH_DEF,
  parameter int unsigned BUCKET_SPAN  = bis_pkg::BUCKET_SPAN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bis_pkg::VAL_W-1:0]  value_i,
  input  logic                       last_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bis_pkg::VAL_W-1:0]  sorted_value_o,
  output logic                       last_out_o,
  output logic                       empty_res_o,
  output logic [bis_pkg::DROP_W-1:0] dropped_count_o
);

  import bis_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  bis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // storage, insertion and output
  bis_dpath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .BUCKET_SPAN  (BUCKET_SPAN)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .value_i         (value_i),
    .last_in_i       (last_in_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .sorted_value_o  (sorted_value_o),
    .last_out_o      (last_out_o),
    .empty_res_o     (empty_res_o),
    .dropped_count_o (dropped_count_o)
  );

endmodule

>>> bench/tb_bucket_insertion_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bucket_insertion_sorter
// Self-checking bench for the bucket insertion sorter. Words are sent over the
// valid/stall input channel. A bucket model inside the bench predicts every
// sorted run, and a sink process compares each output word field by field. The
// bench covers range and bucket edges, empty sets, duplicates, full buckets,
// drop count saturation and a long output hold-off that backs up the input,
// followed by random sets under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_bucket_insertion_sorter;

  import bis_pkg::*;

  localparam int unsigned NB   = NUM_BUCKETS_DEF;
  localparam int unsigned BD   = BUCKET_DEPTH_DEF;
  localparam int unsigned SPAN = BUCKET_SPAN_DEF;

  localparam int RANDOM_WORDS = 32;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_LIMIT = 60;

  // one word of a sorted run
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic              last;
    logic              empty;
    logic [DROP_W-1:0] drops;
  } sorted_word_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [VAL_W-1:0]  value_i     = '0;
  logic              last_in_i   = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [VAL_W-1:0]  sorted_value_o;
  logic              last_out_o;
  logic              empty_res_o;
  logic [DROP_W-1:0] dropped_count_o;

  // bucket model
  logic [VAL_W-1:0]  row_words [NB][BD];
  int unsigned       row_count [NB];
  logic [DROP_W-1:0] set_drops;
  sorted_word_t      sorted_due [$];

  int  mismatches   = 0;
  int  words_sent   = 0;
  int  sets_sent    = 0;
  int  words_seen   = 0;
  int  runs_seen    = 0;
  int  hold_ticket  = 0;
  bit  sender_quiet = 1'b0;

  bucket_insertion_sorter #(
    .NUM_BUCKETS  (NB),
    .BUCKET_DEPTH (BD),
    .BUCKET_SPAN  (SPAN)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_i         (value_i),
    .last_in_i       (last_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sorted_value_o  (sorted_value_o),
    .last_out_o      (last_out_o),
    .empty_res_o     (empty_res_o),
    .dropped_count_o (dropped_count_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // file one word into its bucket; a closing word queues the whole run
  function automatic void place_word(logic [VAL_W-1:0] v, logic closes);
    int unsigned  b;
    int unsigned  pos;
    int unsigned  bb;
    int unsigned  i;
    sorted_word_t w;
    b = v / SPAN;
    if (b >= NB || row_count[b] >= BD) begin
      if (set_drops != DROP_MAX) set_drops++;
    end else begin
      // equal words stay ahead of the newcomer
      pos = row_count[b];
      while (pos > 0 && row_words[b][pos-1] > v) begin
        row_words[b][pos] = row_words[b][pos-1];
        pos--;
      end
      row_words[b][pos] = v;
      row_count[b]++;
    end
    if (closes) begin
      for (bb = 0; bb < NB; bb++) begin
        for (i = 0; i < row_count[bb]; i++) begin
          w.value = row_words[bb][i];
          w.last  = 1'b0;
          w.empty = 1'b0;
          w.drops = set_drops;
          sorted_due.push_back(w);
        end
      end
      if (sorted_due.size() == 0 || sorted_due[$].last) begin
        // nothing stored in this set
        w.value = '0;
        w.last  = 1'b1;
        w.empty = 1'b1;
        w.drops = set_drops;
        sorted_due.push_back(w);
      end else begin
        w = sorted_due.pop_back();
        w.last = 1'b1;
        sorted_due.push_back(w);
      end
      for (bb = 0; bb < NB; bb++) row_count[bb] = 0;
      set_drops = '0;
    end
  endfunction

  function automatic void check_field(string name, int due, int got);
    if (due != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t ns: %s expected %0d got %0d", $time, name, due, got);
    end
  endfunction

  // send one word, with a random gap ahead of it unless the sender is quiet
  task automatic send_word(input logic [VAL_W-1:0] v, input logic closes);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_in_i  <= closes;
    do @(posedge clk_i); while (in_stall_o);
    place_word(v, closes);
    words_sent++;
    if (closes) sets_sent++;
  endtask

  // sets with nothing stored, alone and twice in a row
  task automatic test_empty_set();
    send_word(7'd127, 1'b1);
    send_word(7'd80, 1'b1);
  endtask

  // range ends and bucket edges
  task automatic test_extremes();
    send_word(7'd79, 1'b0);
    send_word(7'd0, 1'b0);
    send_word(7'd80, 1'b0);
    send_word(7'd127, 1'b0);
    send_word(7'd9, 1'b0);
    send_word(7'd10, 1'b0);
    send_word(7'd70, 1'b0);
    send_word(7'd69, 1'b0);
    send_word(7'd40, 1'b1);
  endtask

  task automatic test_equal_values();
    send_word(7'd5, 1'b0);
    send_word(7'd3, 1'b0);
    send_word(7'd5, 1'b0);
    send_word(7'd5, 1'b0);
    send_word(7'd3, 1'b0);
    send_word(7'd5, 1'b1);
  endtask

  // descending words overflow one bucket, plus one out of range
  task automatic test_bucket_full();
    int i;
    for (i = 0; i <= BD; i++) send_word(VAL_W'(3 * SPAN - 1 - i), 1'b0);
    send_word(7'd100, 1'b0);
    send_word(7'd3, 1'b1);
  endtask

  // enough drops in one set to pin the counter
  task automatic test_drop_saturation();
    int i;
    send_word(7'd55, 1'b0);
    send_word(7'd12, 1'b0);
    send_word(7'd12, 1'b0);
    for (i = 0; i < 130; i++)
      send_word(VAL_W'($urandom_range(NB * SPAN, 127)), 1'b0);
    send_word(7'd0, 1'b1);
  endtask

  // receiver holds off while words keep coming, so the input backs up
  task automatic test_back_pressure();
    int i;
    sender_quiet = 1'b1;
    hold_ticket <= hold_ticket + 1;
    for (i = 0; i < 40; i++) send_word(VAL_W'((i * 37) % (NB * SPAN)), i == 39);
    for (i = 0; i < 16; i++)
      send_word(VAL_W'($urandom_range(0, NB * SPAN - 1)), i == 15);
    sender_quiet = 1'b0;
  endtask

  // random sets: mostly in-range words, some packed into few buckets, some noisy
  task automatic test_random_sets();
    int sent;
    int size;
    int kind;
    int r;
    int i;
    int focus_a;
    int focus_b;
    logic [VAL_W-1:0] v;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) size = $urandom_range(1, 12);
      else if (r < 95) size = $urandom_range(13, 40);
      else size = $urandom_range(41, 72);
      if (size > RANDOM_WORDS - sent) size = RANDOM_WORDS - sent;
      kind    = $urandom_range(0, 3);
      focus_a = $urandom_range(0, NB - 1);
      focus_b = $urandom_range(0, NB - 1);
      for (i = 0; i < size; i++) begin
        case (kind)
          2: begin
            v = VAL_W'(($urandom_range(0, 1) ? focus_a : focus_b) * SPAN
                       + $urandom_range(0, SPAN - 1));
          end
          3: begin
            v = VAL_W'($urandom_range(0, 127));
          end
          default: begin
            v = VAL_W'($urandom_range(0, NB * SPAN - 1));
          end
        endcase
        send_word(v, i == size - 1);
      end
      sent += size;
    end
    sender_quiet = 1'b0;
  endtask

  // output sink: checks each accepted word and drives the stall
  initial begin : sorted_word_sink
    int           r;
    int           seen_ticket;
    int           hold_left;
    int           stall_left;
    int           free_left;
    logic         stall;
    sorted_word_t due;
    seen_ticket = 0;
    hold_left   = 0;
    stall_left  = 0;
    free_left   = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (last_out_o) runs_seen++;
        if (sorted_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t ns: no word expected, got value %0d last %0b empty %0b drops %0d",
                     $time, sorted_value_o, last_out_o, empty_res_o, dropped_count_o);
        end else begin
          due = sorted_due.pop_front();
          check_field("sorted_value", due.value, sorted_value_o);
          check_field("last_out", due.last, last_out_o);
          check_field("empty_res", due.empty, empty_res_o);
          check_field("dropped_count", due.drops, dropped_count_o);
        end
      end
      // next stall: long hold-off on request, else random bursts and free runs
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          free_left = $urandom_range(20, 80);
          stall     = 1'b0;
        end else if (r < 65) begin
          free_left = $urandom_range(0, 4);
          stall     = 1'b0;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          stall      = 1'b1;
        end
      end
      out_stall_i <= stall;
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin : handshake_watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d words still due",
             IDLE_LIMIT, sorted_due.size());
    $display("tb: failure");
    $finish;
  end

  // test sequence
  initial begin : test_sequence
    int b;
    for (b = 0; b < NB; b++) row_count[b] = 0;
    set_drops = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_set();
    test_extremes();
    test_equal_values();
    test_bucket_full();
    test_drop_saturation();
    test_back_pressure();
    test_random_sets();

    in_valid_i <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d words sent in %0d sets, %0d sorted words checked in %0d runs",
             words_sent, sets_sent, words_seen, runs_seen);
    $display("summary: edges, empty sets, duplicates, full buckets, drop saturation, hold-off");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
